/* rtl/ugmd_pkg.sv */
// ----------------------------------------------------------------------------
// ugmd_pkg
// Shared types and constants of the guarded motor drive: motion and command
// codes, ranger phases, field widths and the packed stream items.
// ----------------------------------------------------------------------------
package ugmd_pkg;

	// field widths
	localparam int DUTY_W     = 7;
	localparam int REV_W      = 9;
	localparam int INTERVAL_W = 22;
	localparam int TIMEOUT_W  = 18;
	localparam int DEAD_W     = 17;
	localparam int DIST_W     = 13;
	localparam int SINCE_W    = 23;
	localparam int CFG_DATA_W = 22;
	localparam int CFG_IDX_W  = 3;
	localparam int REV_US_W   = 15;

	// ranger timing and range, in microsecond ticks
	localparam logic [TIMEOUT_W-1:0] TRIG_LOW_US  = 18'd2;
	localparam logic [TIMEOUT_W-1:0] TRIG_HIGH_US = 18'd10;
	localparam int                   US_PER_CM    = 58;
	localparam logic [TIMEOUT_W-1:0] MIN_WIDTH_US = 18'd116;   // 2 cm
	localparam logic [TIMEOUT_W-1:0] MAX_WIDTH_US = 18'd23200; // 400 cm
	localparam logic [SINCE_W-1:0]   SINCE_MAX    = 23'h7FFFFF;

	// floor(16*w/58) = floor(8*w/29), done as (8*w * RECIP) >> SHIFT,
	// exact for 8*w below 330586
	localparam logic [22:0] DIST_RECIP = 23'd4628198;
	localparam int          DIST_SHIFT = 27;

	localparam logic [DUTY_W-1:0] DUTY_MAX = 7'd100;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SLOW_DUTY   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FAST_DUTY   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REV_STOP_CM = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_US = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_US  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_DEAD_US     = 3'd5;

	// command codes
	localparam logic [2:0] CMD_STOP     = 3'd0;
	localparam logic [2:0] CMD_FORWARD  = 3'd1;
	localparam logic [2:0] CMD_BACKWARD = 3'd2;
	localparam logic [2:0] CMD_LEFT     = 3'd3;
	localparam logic [2:0] CMD_RIGHT    = 3'd4;
	localparam logic [2:0] CMD_SLOW     = 3'd5;
	localparam logic [2:0] CMD_FAST     = 3'd6;

	typedef enum logic [2:0] {
		MOT_STOP     = 3'd0,
		MOT_FORWARD  = 3'd1,
		MOT_BACKWARD = 3'd2,
		MOT_LEFT     = 3'd3,
		MOT_RIGHT    = 3'd4
	} motion_t;

	typedef enum logic [2:0] {
		RNG_IDLE      = 3'd0,
		RNG_TRIG_LOW  = 3'd1,
		RNG_TRIG_HIGH = 3'd2,
		RNG_WAIT_ECHO = 3'd3,
		RNG_ECHO_HIGH = 3'd4
	} rng_phase_t;

	typedef struct packed {
		logic       echo_level;
		logic       command_valid;
		logic [2:0] command_code;
	} in_item_t;

	// ranger report for the tick being processed
	typedef struct packed {
		logic              near;
		logic              done;
		logic              ok;
		logic [DIST_W-1:0] distance;
		logic              trigger;
	} rng_out_t;

	// drive report for the tick being processed
	typedef struct packed {
		logic              left_a;
		logic              left_b;
		logic              right_a;
		logic              right_b;
		logic [DUTY_W-1:0] duty;
		motion_t           motion;
		logic              close;
	} drv_out_t;

	// result item, laid out as m_tdata (last member in the lowest bits)
	typedef struct packed {
		logic              pad;
		logic [2:0]        motion_now;
		logic              too_close;
		logic              reading_done;
		logic              distance_ok;
		logic [DIST_W-1:0] distance_sixteenths;
		logic              trigger_level;
		logic [DUTY_W-1:0] duty_percent;
		logic              right_in_b;
		logic              right_in_a;
		logic              left_in_b;
		logic              left_in_a;
	} out_item_t;

endpackage

/* rtl/ugmd_ranger.sv */
// ----------------------------------------------------------------------------
// ugmd_ranger
// Ultrasonic ranger sequencer: trigger pulse, echo timing with timeouts and
// conversion of the echo width to sixteenths of a centimetre.
// ----------------------------------------------------------------------------
module ugmd_ranger (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                advance,
	input  logic                                echo_level,
	input  logic [ugmd_pkg::INTERVAL_W-1:0]     measure_interval_us,
	input  logic [ugmd_pkg::TIMEOUT_W-1:0]      echo_timeout_us,
	input  logic [ugmd_pkg::REV_US_W-1:0]       rev_stop_us,
	output ugmd_pkg::rng_out_t                  report
);

	ugmd_pkg::rng_phase_t                phase_q, phase_d;
	logic [ugmd_pkg::TIMEOUT_W-1:0]      cnt_q, cnt_d;
	logic [ugmd_pkg::TIMEOUT_W-1:0]      width_q, width_d;
	logic [ugmd_pkg::SINCE_W-1:0]        since_q, since_d;
	logic [ugmd_pkg::DIST_W-1:0]         dist_q, dist_d;
	logic                                ok_q, ok_d;
	logic                                finish, fail, done, near;
	logic [ugmd_pkg::TIMEOUT_W-1:0]      width_x8;
	logic [40:0]                         quot_prod;

	// width is only used when within range (below 2^15), so 8*w fits 18 bits
	assign width_x8  = {width_q[14:0], 3'b000};
	assign quot_prod = 41'(width_x8) * 41'(ugmd_pkg::DIST_RECIP);

	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		width_d = width_q;
		dist_d  = dist_q;
		ok_d    = ok_q;
		finish  = 1'b0;
		fail    = 1'b0;
		done    = 1'b0;
		near    = 1'b0;
		since_d = (since_q != ugmd_pkg::SINCE_MAX) ? since_q + 1'b1 : since_q;

		case (phase_q)
			ugmd_pkg::RNG_IDLE: begin
				if (since_d > {1'b0, measure_interval_us}) begin
					since_d = '0;
					phase_d = ugmd_pkg::RNG_TRIG_LOW;
					cnt_d   = 18'd1;
				end
			end
			ugmd_pkg::RNG_TRIG_LOW: begin
				if (cnt_q >= ugmd_pkg::TRIG_LOW_US) begin
					phase_d = ugmd_pkg::RNG_TRIG_HIGH;
					cnt_d   = 18'd1;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ugmd_pkg::RNG_TRIG_HIGH: begin
				if (cnt_q >= ugmd_pkg::TRIG_HIGH_US) begin
					phase_d = ugmd_pkg::RNG_WAIT_ECHO;
					cnt_d   = '0;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ugmd_pkg::RNG_WAIT_ECHO: begin
				if (echo_level) begin
					phase_d = ugmd_pkg::RNG_ECHO_HIGH;
					width_d = 18'd1;
				end else if (cnt_q >= echo_timeout_us) begin
					fail = 1'b1;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ugmd_pkg::RNG_ECHO_HIGH: begin
				if (!echo_level) begin
					finish = 1'b1;
				end else if (width_q >= echo_timeout_us) begin
					fail = 1'b1;
				end else begin
					width_d = width_q + 1'b1;
				end
			end
			default: begin
				phase_d = ugmd_pkg::RNG_IDLE;
			end
		endcase

		if (finish) begin
			if (width_q < ugmd_pkg::MIN_WIDTH_US || width_q > ugmd_pkg::MAX_WIDTH_US) begin
				fail = 1'b1;
			end else begin
				dist_d  = quot_prod[ugmd_pkg::DIST_SHIFT +: ugmd_pkg::DIST_W];
				ok_d    = 1'b1;
				done    = 1'b1;
				phase_d = ugmd_pkg::RNG_IDLE;
				cnt_d   = '0;
				near    = (width_q < {3'b000, rev_stop_us});
			end
		end
		if (fail) begin
			dist_d  = '0;
			ok_d    = 1'b0;
			done    = 1'b1;
			phase_d = ugmd_pkg::RNG_IDLE;
			cnt_d   = '0;
		end
	end

	always_comb begin
		report.near     = near;
		report.done     = done;
		report.ok       = ok_d;
		report.distance = dist_d;
		report.trigger  = (phase_d == ugmd_pkg::RNG_TRIG_HIGH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ugmd_pkg::RNG_IDLE;
			cnt_q   <= '0;
			width_q <= '0;
			since_q <= '0;
			dist_q  <= '0;
			ok_q    <= 1'b0;
		end else if (advance) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			width_q <= width_d;
			since_q <= since_d;
			dist_q  <= dist_d;
			ok_q    <= ok_d;
		end
	end

endmodule

/* rtl/ugmd_drive.sv */
// ----------------------------------------------------------------------------
// ugmd_drive
// Motion control of the two bridge channels: command decode, dead time
// before each new motion, speed selection and the automatic reverse stop.
// ----------------------------------------------------------------------------
module ugmd_drive (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            advance,
	input  logic                            command_valid,
	input  logic [2:0]                      command_code,
	input  logic                            near,
	input  logic [ugmd_pkg::DEAD_W-1:0]     dead_time_us,
	input  logic [ugmd_pkg::DUTY_W-1:0]     slow_duty,
	input  logic [ugmd_pkg::DUTY_W-1:0]     fast_duty,
	output ugmd_pkg::drv_out_t              report
);

	ugmd_pkg::motion_t               motion_q, motion_d;
	ugmd_pkg::motion_t               pending_q, pending_d;
	logic                            fast_q, fast_d;
	logic                            pend_fast_q, pend_fast_d;
	logic                            appl_fast_q, appl_fast_d;
	logic [ugmd_pkg::DEAD_W-1:0]     dead_q, dead_d;
	logic                            close;
	logic [ugmd_pkg::DUTY_W-1:0]     duty_sel;

	always_comb begin
		motion_d    = motion_q;
		pending_d   = pending_q;
		fast_d      = fast_q;
		pend_fast_d = pend_fast_q;
		appl_fast_d = appl_fast_q;
		dead_d      = dead_q;
		close       = 1'b0;

		// count down the dead time, apply the held motion when it runs out
		if (dead_q != '0) begin
			dead_d = dead_q - 1'b1;
			if (dead_q == 17'd1) begin
				motion_d    = pending_q;
				appl_fast_d = pend_fast_q;
				pending_d   = ugmd_pkg::MOT_STOP;
			end
		end

		if (command_valid) begin
			case (command_code)
				ugmd_pkg::CMD_STOP: begin
					motion_d  = ugmd_pkg::MOT_STOP;
					dead_d    = '0;
					pending_d = ugmd_pkg::MOT_STOP;
				end
				ugmd_pkg::CMD_FORWARD, ugmd_pkg::CMD_BACKWARD,
				ugmd_pkg::CMD_LEFT, ugmd_pkg::CMD_RIGHT: begin
					if (dead_time_us == '0) begin
						motion_d    = ugmd_pkg::motion_t'(command_code);
						appl_fast_d = fast_d;
						dead_d      = '0;
						pending_d   = ugmd_pkg::MOT_STOP;
					end else begin
						motion_d    = ugmd_pkg::MOT_STOP;
						pending_d   = ugmd_pkg::motion_t'(command_code);
						pend_fast_d = fast_d;
						dead_d      = dead_time_us;
					end
				end
				ugmd_pkg::CMD_SLOW: fast_d = 1'b0;
				ugmd_pkg::CMD_FAST: fast_d = 1'b1;
				default: ;
			endcase
		end

		// obstacle close behind while reversing: stop
		if (near && motion_d == ugmd_pkg::MOT_BACKWARD) begin
			motion_d = ugmd_pkg::MOT_STOP;
			close    = 1'b1;
		end
	end

	assign duty_sel = appl_fast_d ? fast_duty : slow_duty;

	always_comb begin
		report.left_a  = 1'b0;
		report.left_b  = 1'b0;
		report.right_a = 1'b0;
		report.right_b = 1'b0;
		report.duty    = '0;
		report.motion  = motion_d;
		report.close   = close;
		case (motion_d)
			ugmd_pkg::MOT_FORWARD: begin
				report.left_a  = 1'b1;
				report.right_a = 1'b1;
			end
			ugmd_pkg::MOT_BACKWARD: begin
				report.left_b  = 1'b1;
				report.right_b = 1'b1;
			end
			ugmd_pkg::MOT_LEFT: begin
				report.left_b  = 1'b1;
				report.right_a = 1'b1;
			end
			ugmd_pkg::MOT_RIGHT: begin
				report.left_a  = 1'b1;
				report.right_b = 1'b1;
			end
			default: ;
		endcase
		if (motion_d != ugmd_pkg::MOT_STOP) begin
			report.duty = (duty_sel > ugmd_pkg::DUTY_MAX) ? ugmd_pkg::DUTY_MAX : duty_sel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motion_q    <= ugmd_pkg::MOT_STOP;
			pending_q   <= ugmd_pkg::MOT_STOP;
			fast_q      <= 1'b0;
			pend_fast_q <= 1'b0;
			appl_fast_q <= 1'b0;
			dead_q      <= '0;
		end else if (advance) begin
			motion_q    <= motion_d;
			pending_q   <= pending_d;
			fast_q      <= fast_d;
			pend_fast_q <= pend_fast_d;
			appl_fast_q <= appl_fast_d;
			dead_q      <= dead_d;
		end
	end

endmodule

/* rtl/ultrasonic_guarded_motor_drive.sv */
// ----------------------------------------------------------------------------
// ultrasonic_guarded_motor_drive
// Two-channel bridge drive with dead time, guarded by an ultrasonic ranger.
// ----------------------------------------------------------------------------
// Usage:
// Each slave-side transfer is one microsecond tick: the sampled echo pin and
// an optional drive command (tuser marks a command). Every tick gives exactly
// one master-side transfer with the bridge pins, duty, trigger pin level, the
// latest distance reading and the event flags for that tick.
// The tick is held in an input register, processed in one pass and the
// result held in an output register, which drives m_tdata; one tick is
// taken per cycle while results flow.
// A stalled receiver holds the result in place; a tick already in the input
// register is held there and tready drops at once until the result moves on
// (an empty input register still takes one more tick first).
// Reset leaves the car stopped, slow speed selected, the ranger idle and the
// registers at their defaults (slow 70 %, fast 90 %, reverse stop 20 cm,
// interval 2 s, echo timeout 250 ms, dead time 100 ms).
// Registers are written on the cfg channel, always ready; write them only
// while no tick is in flight. Indexes outside the list are dropped.
// ----------------------------------------------------------------------------
module ultrasonic_guarded_motor_drive (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [7:0]                         s_tdata,   // echo_level, command_code, zeros
	input  logic                               s_tuser,   // command_valid
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// left_in_a, left_in_b, right_in_a, right_in_b, duty_percent, trigger_level,
	// distance_sixteenths, distance_ok, reading_done, too_close, motion_now, zero
	output logic [31:0]                        m_tdata,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [ugmd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ugmd_pkg::CFG_DATA_W-1:0]    cfg_data
);

	logic [ugmd_pkg::DUTY_W-1:0]      slow_duty_q, fast_duty_q;
	logic [ugmd_pkg::REV_US_W-1:0]    rev_stop_us_q;
	logic [ugmd_pkg::INTERVAL_W-1:0]  interval_q;
	logic [ugmd_pkg::TIMEOUT_W-1:0]   timeout_q;
	logic [ugmd_pkg::DEAD_W-1:0]      dead_time_q;

	ugmd_pkg::in_item_t               item_s1;
	logic                             valid_s1;
	ugmd_pkg::out_item_t              result_q;
	logic                             out_valid_q;
	logic                             advance;
	ugmd_pkg::rng_out_t               rng;
	ugmd_pkg::drv_out_t               drv;
	ugmd_pkg::out_item_t              result_d;
	logic [ugmd_pkg::REV_US_W-1:0]    rev_stop_us_d;

	assign advance   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = result_q;
	assign cfg_ready = 1'b1;

	// reverse stop threshold kept as an echo width in ticks
	assign rev_stop_us_d = ugmd_pkg::REV_US_W'(cfg_data[ugmd_pkg::REV_W-1:0] *
		ugmd_pkg::REV_US_W'(ugmd_pkg::US_PER_CM));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slow_duty_q   <= 7'd70;
			fast_duty_q   <= 7'd90;
			rev_stop_us_q <= 15'd1160;
			interval_q    <= 22'd2000000;
			timeout_q     <= 18'd250000;
			dead_time_q   <= 17'd100000;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ugmd_pkg::CFG_SLOW_DUTY:   slow_duty_q   <= cfg_data[ugmd_pkg::DUTY_W-1:0];
				ugmd_pkg::CFG_FAST_DUTY:   fast_duty_q   <= cfg_data[ugmd_pkg::DUTY_W-1:0];
				ugmd_pkg::CFG_REV_STOP_CM: rev_stop_us_q <= rev_stop_us_d;
				ugmd_pkg::CFG_INTERVAL_US: interval_q    <= cfg_data[ugmd_pkg::INTERVAL_W-1:0];
				ugmd_pkg::CFG_TIMEOUT_US:  timeout_q     <= cfg_data[ugmd_pkg::TIMEOUT_W-1:0];
				ugmd_pkg::CFG_DEAD_US:     dead_time_q   <= cfg_data[ugmd_pkg::DEAD_W-1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.echo_level    <= s_tdata[0];
			item_s1.command_valid <= s_tuser;
			item_s1.command_code  <= s_tdata[3:1];
		end
	end

	ugmd_ranger u_ranger (
		.clk                 (clk),
		.arst_n              (arst_n),
		.advance             (advance),
		.echo_level          (item_s1.echo_level),
		.measure_interval_us (interval_q),
		.echo_timeout_us     (timeout_q),
		.rev_stop_us         (rev_stop_us_q),
		.report              (rng)
	);

	ugmd_drive u_drive (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.command_valid (item_s1.command_valid),
		.command_code  (item_s1.command_code),
		.near          (rng.near),
		.dead_time_us  (dead_time_q),
		.slow_duty     (slow_duty_q),
		.fast_duty     (fast_duty_q),
		.report        (drv)
	);

	always_comb begin
		result_d.pad                 = 1'b0;
		result_d.motion_now          = drv.motion;
		result_d.too_close           = drv.close;
		result_d.reading_done        = rng.done;
		result_d.distance_ok         = rng.ok;
		result_d.distance_sixteenths = rng.distance;
		result_d.trigger_level       = rng.trigger;
		result_d.duty_percent        = drv.duty;
		result_d.right_in_b          = drv.right_b;
		result_d.right_in_a          = drv.right_a;
		result_d.left_in_b           = drv.left_b;
		result_d.left_in_a           = drv.left_a;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_d;
		end
	end

	// a held tick is never dropped while the output is stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("held tick lost while output stalled");

	// stopped means all bridge pins low and no duty
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.motion_now == ugmd_pkg::MOT_STOP |->
		result_q.duty_percent == '0 && !result_q.left_in_a && !result_q.left_in_b &&
		!result_q.right_in_a && !result_q.right_in_b)
		else $error("bridge driven while stopped");

	// never both inputs of one bridge high
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(result_q.left_in_a && result_q.left_in_b) &&
		!(result_q.right_in_a && result_q.right_in_b))
		else $error("bridge shoot-through");

	// an automatic stop comes only with a good reading
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.too_close |->
		result_q.reading_done && result_q.distance_ok &&
		result_q.motion_now == ugmd_pkg::MOT_STOP)
		else $error("reverse stop without a valid reading");

	// a finished reading returns the ranger to idle, trigger low
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.reading_done |-> !result_q.trigger_level)
		else $error("trigger high on reading completion");

endmodule

/* tb/ugmd_checker.sv */
// ----------------------------------------------------------------------------
// ugmd_checker
// Watches the tick, result and register channels of the guarded motor drive.
// Each accepted tick is run through a tick-by-tick model of the drive and the
// ranger. The model's pin set is queued, and each result transfer is compared
// field by field with the oldest queued pin set.
// ----------------------------------------------------------------------------
module ugmd_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [7:0]                      s_tdata,   // echo_level, command_code, zeros
	input  logic                            s_tuser,   // command_valid
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	// left_in_a, left_in_b, right_in_a, right_in_b, duty_percent, trigger_level,
	// distance_sixteenths, distance_ok, reading_done, too_close, motion_now, zero
	input  logic [31:0]                     m_tdata,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [ugmd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ugmd_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                              fail_count,
	output int                              outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import ugmd_pkg::*;

	localparam int             TRIG_LOW_TICKS  = 2;
	localparam int             TRIG_HIGH_TICKS = 10;
	localparam int             TICKS_PER_CM    = 58;
	localparam int             MIN_ECHO_TICKS  = 116;
	localparam int             MAX_ECHO_TICKS  = 23200;
	localparam logic [6:0]     DUTY_CEIL       = 7'd100;

	// register copies
	logic [6:0]  slow_pct, fast_pct;
	logic [8:0]  stop_cm;
	logic [21:0] interval_us;
	logic [17:0] timeout_us;
	logic [16:0] dead_us;

	// drive state
	motion_t     drive_motion, pend_motion;
	logic        fast_sel, pend_fast, used_fast;
	logic [16:0] dead_left;

	// ranger state
	rng_phase_t  phase;
	logic [21:0] phase_cnt;
	logic [17:0] width_cnt;
	logic [12:0] range16;
	logic        range_ok;
	logic [22:0] ticks_since;

	out_item_t   pin_sets_q[$];
	int          results_seen;

	task automatic report_fault(input string msg);
		fail_count++;
		$display("[%0t] mismatch: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [15:0] got, input logic [15:0] want);
		if (got !== want)
			report_fault($sformatf("result %0d %s got %0d want %0d",
				results_seen, name, got, want));
	endtask

	// one microsecond tick: dead time, command, ranger, then the pins
	function automatic out_item_t next_pin_set(input logic echo, input logic cmd_valid,
			input logic [2:0] code);
		out_item_t  o;
		logic       done, near, fail, finish;
		logic [6:0] pct;
		int         w;
		o = '0;
		done = 1'b0;
		near = 1'b0;
		fail = 1'b0;
		finish = 1'b0;

		if (dead_left != '0) begin
			dead_left = dead_left - 1'b1;
			if (dead_left == '0) begin
				drive_motion = pend_motion;
				used_fast = pend_fast;
				pend_motion = MOT_STOP;
			end
		end

		if (cmd_valid) begin
			case (code)
				CMD_STOP: begin
					drive_motion = MOT_STOP;
					dead_left = '0;
					pend_motion = MOT_STOP;
				end
				CMD_FORWARD, CMD_BACKWARD, CMD_LEFT, CMD_RIGHT: begin
					if (dead_us == '0) begin
						drive_motion = motion_t'(code);
						used_fast = fast_sel;
						dead_left = '0;
						pend_motion = MOT_STOP;
					end else begin
						// hold all pins low until the dead time runs out
						drive_motion = MOT_STOP;
						pend_motion = motion_t'(code);
						pend_fast = fast_sel;
						dead_left = dead_us;
					end
				end
				CMD_SLOW: fast_sel = 1'b0;
				CMD_FAST: fast_sel = 1'b1;
				default: ;
			endcase
		end

		if (ticks_since != '1)
			ticks_since = ticks_since + 1'b1;
		case (phase)
			RNG_IDLE: begin
				if (ticks_since > interval_us) begin
					ticks_since = '0;
					phase = RNG_TRIG_LOW;
					phase_cnt = 22'd1;
				end
			end
			RNG_TRIG_LOW: begin
				if (phase_cnt >= TRIG_LOW_TICKS) begin
					phase = RNG_TRIG_HIGH;
					phase_cnt = 22'd1;
				end else
					phase_cnt = phase_cnt + 1'b1;
			end
			RNG_TRIG_HIGH: begin
				if (phase_cnt >= TRIG_HIGH_TICKS) begin
					phase = RNG_WAIT_ECHO;
					phase_cnt = '0;
				end else
					phase_cnt = phase_cnt + 1'b1;
			end
			RNG_WAIT_ECHO: begin
				if (echo) begin
					phase = RNG_ECHO_HIGH;
					width_cnt = 18'd1;
				end else if (phase_cnt >= timeout_us)
					fail = 1'b1;
				else
					phase_cnt = phase_cnt + 1'b1;
			end
			RNG_ECHO_HIGH: begin
				if (!echo)
					finish = 1'b1;
				else if (width_cnt >= timeout_us)
					fail = 1'b1;
				else
					width_cnt = width_cnt + 1'b1;
			end
			default: phase = RNG_IDLE;
		endcase

		if (finish) begin
			w = int'(width_cnt);
			if (w < MIN_ECHO_TICKS || w > MAX_ECHO_TICKS)
				fail = 1'b1;
			else begin
				range16 = 13'((w * 16) / TICKS_PER_CM);
				range_ok = 1'b1;
				done = 1'b1;
				phase = RNG_IDLE;
				phase_cnt = '0;
				// stop a reversing car on a near obstacle; the pending motion stays
				if (drive_motion == MOT_BACKWARD && w < stop_cm * TICKS_PER_CM) begin
					drive_motion = MOT_STOP;
					near = 1'b1;
				end
			end
		end
		if (fail) begin
			range16 = '0;
			range_ok = 1'b0;
			done = 1'b1;
			phase = RNG_IDLE;
			phase_cnt = '0;
		end

		case (drive_motion)
			MOT_FORWARD: begin
				o.left_in_a = 1'b1;
				o.right_in_a = 1'b1;
			end
			MOT_BACKWARD: begin
				o.left_in_b = 1'b1;
				o.right_in_b = 1'b1;
			end
			MOT_LEFT: begin
				o.left_in_b = 1'b1;
				o.right_in_a = 1'b1;
			end
			MOT_RIGHT: begin
				o.left_in_a = 1'b1;
				o.right_in_b = 1'b1;
			end
			default: ;
		endcase
		if (drive_motion != MOT_STOP) begin
			pct = used_fast ? fast_pct : slow_pct;
			o.duty_percent = (pct > DUTY_CEIL) ? DUTY_CEIL : pct;
		end
		o.trigger_level = (phase == RNG_TRIG_HIGH);
		o.distance_sixteenths = range16;
		o.distance_ok = range_ok;
		o.reading_done = done;
		o.too_close = near;
		o.motion_now = drive_motion;
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t got, want;
		if (!arst_n) begin
			// register defaults
			slow_pct = 7'd70;
			fast_pct = 7'd90;
			stop_cm = 9'd20;
			interval_us = 22'd2000000;
			timeout_us = 18'd250000;
			dead_us = 17'd100000;
			drive_motion = MOT_STOP;
			pend_motion = MOT_STOP;
			fast_sel = 1'b0;
			pend_fast = 1'b0;
			used_fast = 1'b0;
			dead_left = '0;
			phase = RNG_IDLE;
			phase_cnt = '0;
			width_cnt = '0;
			range16 = '0;
			range_ok = 1'b0;
			ticks_since = '0;
			pin_sets_q.delete();
			results_seen = 0;
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_SLOW_DUTY:   slow_pct = cfg_data[6:0];
					CFG_FAST_DUTY:   fast_pct = cfg_data[6:0];
					CFG_REV_STOP_CM: stop_cm = cfg_data[8:0];
					CFG_INTERVAL_US: interval_us = cfg_data[21:0];
					CFG_TIMEOUT_US:  timeout_us = cfg_data[17:0];
					CFG_DEAD_US:     dead_us = cfg_data[16:0];
					default: ;
				endcase
			end

			// retire before queueing: a tick never leaves in the edge it enters
			if (m_tvalid && m_tready) begin
				got = out_item_t'(m_tdata);
				if (pin_sets_q.size() == 0)
					report_fault($sformatf("result %0d arrived with no tick waiting",
						results_seen));
				else begin
					want = pin_sets_q.pop_front();
					check_field("left_in_a", 16'(got.left_in_a), 16'(want.left_in_a));
					check_field("left_in_b", 16'(got.left_in_b), 16'(want.left_in_b));
					check_field("right_in_a", 16'(got.right_in_a), 16'(want.right_in_a));
					check_field("right_in_b", 16'(got.right_in_b), 16'(want.right_in_b));
					check_field("duty_percent", 16'(got.duty_percent),
						16'(want.duty_percent));
					check_field("trigger_level", 16'(got.trigger_level),
						16'(want.trigger_level));
					check_field("distance_sixteenths", 16'(got.distance_sixteenths),
						16'(want.distance_sixteenths));
					check_field("distance_ok", 16'(got.distance_ok), 16'(want.distance_ok));
					check_field("reading_done", 16'(got.reading_done),
						16'(want.reading_done));
					check_field("too_close", 16'(got.too_close), 16'(want.too_close));
					check_field("motion_now", 16'(got.motion_now), 16'(want.motion_now));
				end
				results_seen++;
			end

			if (s_tvalid && s_tready)
				pin_sets_q.push_back(next_pin_set(s_tdata[0], s_tuser, s_tdata[3:1]));

			outstanding <= pin_sets_q.size();
		end
	end

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the guarded motor drive: a short directed run over every
// command and the dead time rules, then echo sequences of chosen widths under
// several register settings. Both stream sides idle at random. Checking is
// done by ugmd_checker.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import ugmd_pkg::*;

	localparam logic [2:0] CMD_UNUSED = 3'd7;
	localparam int         IDLE_PCT   = 14;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [7:0]            s_tdata = '0;
	logic                  s_tuser = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [31:0]           m_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int                    fail_count;
	int                    outstanding;
	logic                  calm = 1'b0;
	int                    ticks_sent = 0;
	int                    stop_ticks;
	int                    echo_limit;

	ultrasonic_guarded_motor_drive dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	ugmd_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk)
		m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);

	initial begin
		#8_000_000;
		$display("FAILURE");
		$finish;
	end

	task automatic send_tick(input logic echo, input logic cmd_valid, input logic [2:0] code);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0000, code, echo};
		s_tuser <= cmd_valid;
		do @(posedge clk); while (!s_tready);
		ticks_sent++;
	endtask

	// random commands only where allowed, so a reversing car can survive an echo
	task automatic send_echo_tick(input logic echo, input logic allow_cmd);
		int roll;
		roll = $urandom_range(99);
		if (allow_cmd && roll < 3)
			send_tick(echo, 1'b1, CMD_BACKWARD);
		else if (allow_cmd && roll < 8)
			send_tick(echo, 1'b1, 3'($urandom_range(7)));
		else
			send_tick(echo, 1'b0, 3'($urandom_range(7)));
	endtask

	// hold off until every tick has been answered, then let the pipeline settle
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[CFG_DATA_W-1:0];
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic apply_setting(input int slow, input int fast, input int stop_cm,
			input int interval, input int timeout, input int dead);
		drain();
		write_reg(CFG_SLOW_DUTY, slow);
		write_reg(CFG_FAST_DUTY, fast);
		write_reg(CFG_REV_STOP_CM, stop_cm);
		write_reg(CFG_INTERVAL_US, interval);
		write_reg(CFG_TIMEOUT_US, timeout);
		write_reg(CFG_DEAD_US, dead);
		cfg_valid <= 1'b0;
		stop_ticks = stop_cm * 58;
		echo_limit = timeout;
	endtask

	function automatic int pick_width();
		int roll;
		roll = $urandom_range(99);
		if (roll < 35)
			return $urandom_range(1, 115);
		if (roll < 55)
			return $urandom_range(116, 130);
		if (roll < 75 && stop_ticks >= 4 && stop_ticks <= 1000)
			return $urandom_range(stop_ticks - 3, stop_ticks + 3);
		if (roll < 88 || echo_limit > 1000)
			return $urandom_range(116, 400);
		return echo_limit + $urandom_range(1, 5);
	endfunction

	// echo episodes: a low stretch then a high pulse of chosen width, with some noise
	task automatic run_phase(input int budget);
		int stop_at, low_len, high_len, n;
		stop_at = ticks_sent + budget;
		while (ticks_sent < stop_at) begin
			if ($urandom_range(99) < 15) begin
				n = $urandom_range(1, 30);
				repeat (n) send_echo_tick(1'($urandom_range(1)), 1'b1);
			end else begin
				low_len = $urandom_range(0, 40);
				high_len = pick_width();
				repeat (low_len) send_echo_tick(1'b0, 1'b1);
				if ($urandom_range(1))
					send_tick(1'b1, 1'b1, CMD_BACKWARD);
				else
					send_echo_tick(1'b1, 1'b0);
				repeat (high_len - 1) send_echo_tick(1'b1, 1'b0);
			end
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed: duty above the ceiling, short dead time, back-to-back measurements
		apply_setting(127, 100, 511, 0, 2, 2);
		send_tick(1'b0, 1'b1, CMD_FORWARD);
		send_tick(1'b0, 1'b0, CMD_UNUSED);
		send_tick(1'b1, 1'b0, CMD_STOP);
		send_tick(1'b0, 1'b1, CMD_FAST);
		send_tick(1'b0, 1'b1, CMD_BACKWARD);
		send_tick(1'b1, 1'b1, CMD_LEFT);       // restart inside the dead time
		send_tick(1'b0, 1'b0, CMD_STOP);
		send_tick(1'b1, 1'b1, CMD_RIGHT);
		send_tick(1'b0, 1'b1, CMD_STOP);       // cancel the pending motion
		send_tick(1'b0, 1'b1, CMD_UNUSED);
		send_tick(1'b1, 1'b1, CMD_SLOW);
		send_tick(1'b0, 1'b1, CMD_LEFT);
		send_tick(1'b0, 1'b0, CMD_STOP);
		send_tick(1'b1, 1'b0, CMD_UNUSED);
		send_tick(1'b1, 1'b1, CMD_FAST);
		send_tick(1'b1, 1'b1, CMD_RIGHT);
		send_tick(1'b0, 1'b1, CMD_FORWARD);
		send_tick(1'b1, 1'b0, CMD_SLOW);
		send_tick(1'b1, 1'b0, CMD_STOP);
		send_tick(1'b1, 1'b0, CMD_STOP);
		send_tick(1'b0, 1'b0, CMD_STOP);
		send_tick(1'b0, 1'b0, CMD_STOP);
		send_tick(1'b1, 1'b0, CMD_STOP);
		send_tick(1'b0, 1'b0, CMD_STOP);

		apply_setting(70, 90, 4, 0, 300, 0);
		run_phase(200);

		// no idling on either side through this phase
		apply_setting(0, 127, 511, 1, 400, 3);
		calm <= 1'b1;
		run_phase(200);
		calm <= 1'b0;

		apply_setting(100, 0, 0, 25, 0, 1);
		run_phase(150);

		apply_setting(55, 66, 300, 4194303, 262143, 131071);
		run_phase(100);

		apply_setting(70, 90, 400, 0, 30000, 1);
		run_phase(200);

		drain();
		if (fail_count == 0 && outstanding == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
